// ===== hdl/keyed_slot_table_unit_defines.svh =====
// Assertion macros shared by the keyed slot table unit.
`ifndef KEYED_SLOT_TABLE_UNIT_DEFINES_SVH
`define KEYED_SLOT_TABLE_UNIT_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define KST_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("keyed slot table check failed");

// The condition must hold in the cycle after the trigger.
`define KST_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("keyed slot table check failed");

`endif

// ===== hdl/kst_pkg.sv =====
// Types and constants shared by the keyed slot table unit.
package kst_pkg;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [16:0] ID_NONE   = 17'h1FFFF;
   localparam logic [4:0]  CSR_RESET = 5'd16;
   // Wide enough to compare a slot count of up to 256.
   localparam int          CMP_W     = 9;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  key;
      logic [31:0] data;
   } entry_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hit;
      logic exhausted;
   } ctrl_sts_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

endpackage

// ===== hdl/kst_ram.sv =====
// Generic single-port RAM with registered read data.
module kst_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic                                    re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                        wdata,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/kst_ctrl.sv =====
// Controller state machine that sequences the slot scan of one beat.
module kst_ctrl import kst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      done;
   logic      out_free;

   assign done     = sts.hit || sts.exhausted;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!done) begin
               cmd.scan = 1'b1;
            end else if (out_free) begin
               // The result waits here until the output register frees up.
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/kst_datapath.sv =====
// Datapath: slot storage, valid bits, scan pointer, key compare and result register.
module kst_datapath import kst_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data,
   input  logic               req_command,
   input  logic [15:0]        req_entry_id,
   input  logic [7:0]         req_entry_key,
   input  logic [31:0]        req_entry_data,
   input  logic [7:0]         req_lookup_key,
   input  ctrl_cmd_type       cmd,
   output ctrl_sts_type       sts,
   output logic               rsp_stored,
   output logic               rsp_found,
   output logic [3:0]         rsp_slot_index,
   output logic signed [16:0] rsp_out_id,
   output logic [7:0]         rsp_out_key,
   output logic [31:0]        rsp_out_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   logic [4:0]       csr_ff;
   logic             cmd_ff;
   entry_type        entry_ff;
   logic [7:0]       lookup_ff;
   logic [CNT_W-1:0] addr_ff;
   logic [IDX_W-1:0] probe_ff;
   logic             pend_ff;
   logic [SLOTS-1:0] valid_ff;

   logic               stored_ff;
   logic               found_ff;
   logic [3:0]         slot_ff;
   logic signed [16:0] out_id_ff;
   logic [7:0]         out_key_ff;
   logic [31:0]        out_data_ff;

   logic [CMP_W-1:0] lim;
   logic             more;
   logic             probe_valid;
   logic             hit;
   logic             ram_we;
   logic             ram_re;
   logic [IDX_W-1:0] ram_addr;
   entry_type        ram_rdata;
   logic [15:0]      probe_wide;

   // A limit above the table size saturates to the table size.
   assign lim  = (CMP_W'(csr_ff) > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : CMP_W'(csr_ff);
   assign more = CMP_W'(addr_ff) < lim;

   assign probe_valid = valid_ff[probe_ff];
   assign hit = pend_ff && ((cmd_ff == CMD_WRITE) ? !probe_valid
                            : (probe_valid && (ram_rdata.key == lookup_ff)));

   assign sts.hit       = hit;
   assign sts.exhausted = !pend_ff && !more;

   assign ram_re   = cmd.scan && more;
   assign ram_we   = cmd.finish && hit && (cmd_ff == CMD_WRITE);
   assign ram_addr = ram_we ? probe_ff : addr_ff[IDX_W-1:0];

   kst_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (entry_ff),
      .rdata (ram_rdata)
   );

   assign probe_wide = 16'(probe_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff   <= CSR_RESET;
         valid_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            csr_ff <= csr_write_data;
         end
         if (cmd.start) begin
            pend_ff <= 1'b0;
         end else if (cmd.scan) begin
            pend_ff <= more;
         end
         if (cmd.finish && hit) begin
            valid_ff[probe_ff] <= (cmd_ff == CMD_WRITE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cmd_ff         <= req_command;
         entry_ff.id    <= req_entry_id;
         entry_ff.key   <= req_entry_key;
         entry_ff.data  <= req_entry_data;
         lookup_ff      <= req_lookup_key;
         addr_ff        <= '0;
      end else if (cmd.scan && more) begin
         probe_ff <= addr_ff[IDX_W-1:0];
         addr_ff  <= addr_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         stored_ff <= hit && (cmd_ff == CMD_WRITE);
         found_ff  <= hit && (cmd_ff == CMD_READ);
         slot_ff   <= hit ? probe_wide[3:0] : 4'd0;
         if (hit && (cmd_ff == CMD_READ)) begin
            out_id_ff   <= signed'({1'b0, ram_rdata.id});
            out_key_ff  <= ram_rdata.key;
            out_data_ff <= ram_rdata.data;
         end else begin
            out_id_ff   <= signed'(ID_NONE);
            out_key_ff  <= 8'd0;
            out_data_ff <= 32'd0;
         end
      end
   end

   assign rsp_stored     = stored_ff;
   assign rsp_found      = found_ff;
   assign rsp_slot_index = slot_ff;
   assign rsp_out_id     = out_id_ff;
   assign rsp_out_key    = out_key_ff;
   assign rsp_out_data   = out_data_ff;

endmodule

// ===== hdl/keyed_slot_table_unit.sv =====
// Top level of the keyed slot table unit: controller, datapath and checks.
//
// Usage: a request beat carries a command. A write stores entry_id, entry_key
// and entry_data in the lowest free slot among the first slots_in_use slots;
// a read takes, frees and returns the lowest valid entry whose key equals
// lookup_key. Each request beat gives exactly one response beat: stored or
// found, the slot index, and on a read hit the entry (otherwise out_id is -1).
// slots_in_use, written through csr_write_enable and csr_write_data, resets to
// 16 and saturates at SLOTS; the user must write it only while the unit is idle,
// which the unit itself does not enforce.
// Timing: the scan reads one slot per cycle from the slot RAM, with the key
// compare in the cycle after the read. One beat is in work at a time;
// req_stall is high from acceptance until the result is loaded into the output
// register, and the next request is taken in the following cycle while the
// previous response still waits.
// Reset empties the table at once (valid bits in flops) and drops any
// pending response. If rsp_stall holds a response, a finished scan waits and
// no further request is taken until the output register frees up.
`include "keyed_slot_table_unit_defines.svh"

module keyed_slot_table_unit import kst_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [15:0]        req_entry_id,
   input  logic [7:0]         req_entry_key,
   input  logic [31:0]        req_entry_data,
   input  logic [7:0]         req_lookup_key,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_stored,
   output logic               rsp_found,
   output logic [3:0]         rsp_slot_index,
   output logic signed [16:0] rsp_out_id,
   output logic [7:0]         rsp_out_key,
   output logic [31:0]        rsp_out_data,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   kst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   kst_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_command      (req_command),
      .req_entry_id     (req_entry_id),
      .req_entry_key    (req_entry_key),
      .req_entry_data   (req_entry_data),
      .req_lookup_key   (req_lookup_key),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_stored       (rsp_stored),
      .rsp_found        (rsp_found),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_key      (rsp_out_key),
      .rsp_out_data     (rsp_out_data)
   );

   // A response never reports both a stored write and a found read.
   `KST_ASSERT_SAME(a_not_both, rsp_valid, !(rsp_stored && rsp_found))
   // A response without a hit carries the empty entry.
   `KST_ASSERT_SAME(a_miss_empty, rsp_valid && !rsp_found,
      (rsp_out_id == signed'(ID_NONE)) && (rsp_out_key == 8'd0) && (rsp_out_data == 32'd0))
   // The result is loaded only once the scan has hit or run out of slots.
   `KST_ASSERT_SAME(a_finish_done, cmd.finish, sts.hit || sts.exhausted)
   // An accepted beat makes the unit busy in the next cycle.
   `KST_ASSERT_NEXT(a_start_busy, cmd.start, req_stall)

endmodule
